>>> hw/rtl/gpc_pkg.sv
// gpc_pkg: shared types, constants and codes for the geofence point checker
// no dependencies
package gpc_pkg;

  localparam int MAX_POLYGONS_D   = 8;
  localparam int MAX_VERTICES_D   = 64;
  localparam int COORD_BITS_D     = 24;
  localparam int MIN_POLY_VERTS   = 3;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    OP_WRITE_VTX = 2'd0,
    OP_SET_POLY  = 2'd1,
    OP_QUERY     = 2'd2,
    OP_CLEAR     = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         polygon_index;
    logic [5:0]         vertex_index;
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
    logic [6:0]         vertex_count;
    logic               hard_zone;
  } in_word_t;

  typedef struct packed {
    logic       allowed;
    logic       inside_perimeter;
    logic       blocked_by_exclusion;
    logic [2:0] blocking_index;
  } out_word_t;

  // back end states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POLY,
    ST_RD,
    ST_MUL,
    ST_CMP,
    ST_NEXT,
    ST_OUT
  } walk_state_t;

endpackage

>>> hw/rtl/gpc_front.sv
// gpc_front: accepts words, applies writes and table updates, queues queries
// depends on gpc_pkg
module gpc_front
  import gpc_pkg::*;
#(
  parameter int MAX_POLYGONS = MAX_POLYGONS_D,
  parameter int MAX_VERTICES = MAX_VERTICES_D,
  parameter int COORD_BITS   = COORD_BITS_D,
  localparam int PB = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1,
  localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int CB = $clog2(MAX_VERTICES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  in_word_t                      in_data,
  // vertex write port
  output logic                          vw_en,
  output logic [PB+VB-1:0]              vw_addr,
  output logic signed [COORD_BITS-1:0]  vw_x,
  output logic signed [COORD_BITS-1:0]  vw_y,
  // tables
  output logic [MAX_POLYGONS-1:0][CB-1:0] size_tab,
  output logic [MAX_POLYGONS-1:0]       hard_tab,
  // query queue
  output logic                          q_valid,
  input  logic                          q_pop,
  input  logic                          walk_busy,
  output logic signed [COORD_BITS-1:0]  q_x,
  output logic signed [COORD_BITS-1:0]  q_y
);

  localparam int QB = $clog2(QUEUE_DEPTH);

  logic [MAX_POLYGONS-1:0][CB-1:0] size_r;
  logic [MAX_POLYGONS-1:0]         hard_r;
  logic signed [COORD_BITS-1:0] qx_r [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] qy_r [QUEUE_DEPTH];
  logic [QB-1:0] wp_r, rp_r;
  logic [QB:0]   cnt_r;
  logic          acc, push, poly_ok, vtx_ok;
  logic [CB-1:0] cnt_sat;

  // table and vertex updates wait until the back end has drained
  assign in_stall = (cnt_r == (QB+1)'(QUEUE_DEPTH)) ||
                    (in_data.opcode != OP_QUERY && (walk_busy || cnt_r != '0));
  assign acc      = in_valid && !in_stall;
  assign push     = acc && in_data.opcode == OP_QUERY;
  assign poly_ok  = 32'(in_data.polygon_index) < MAX_POLYGONS;
  assign vtx_ok   = 32'(in_data.vertex_index) < MAX_VERTICES;
  assign cnt_sat  = (32'(in_data.vertex_count) > MAX_VERTICES) ? CB'(MAX_VERTICES)
                  : CB'(in_data.vertex_count);

  assign vw_en   = acc && in_data.opcode == OP_WRITE_VTX && poly_ok && vtx_ok;
  assign vw_addr = {PB'(in_data.polygon_index), VB'(in_data.vertex_index)};
  assign vw_x    = COORD_BITS'(in_data.x_coord);
  assign vw_y    = COORD_BITS'(in_data.y_coord);
  assign size_tab = size_r;
  assign hard_tab = hard_r;
  assign q_valid  = cnt_r != '0;
  assign q_x      = qx_r[rp_r];
  assign q_y      = qy_r[rp_r];

  // polygon tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      hard_r <= '1;
    end else if (acc && in_data.opcode == OP_CLEAR) begin
      size_r <= '0;
      hard_r <= '1;
    end else if (acc && in_data.opcode == OP_SET_POLY && poly_ok) begin
      size_r[PB'(in_data.polygon_index)] <= cnt_sat;
      hard_r[PB'(in_data.polygon_index)] <= in_data.hard_zone;
    end
  end

  // query queue
  always_ff @(posedge clk) begin
    if (push) begin
      qx_r[wp_r] <= COORD_BITS'(in_data.x_coord);
      qy_r[wp_r] <= COORD_BITS'(in_data.y_coord);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QB+1)'(push) - (QB+1)'(q_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QB+1)'(QUEUE_DEPTH)) else $error("queue overflow");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    vw_en |-> !walk_busy && cnt_r == '0) else $error("vertex write during query");
`endif

endmodule

>>> hw/rtl/gpc_back.sv
// gpc_back: walks polygon edges for one query, one edge at a time
// depends on gpc_pkg
module gpc_back
  import gpc_pkg::*;
#(
  parameter int MAX_POLYGONS = MAX_POLYGONS_D,
  parameter int MAX_VERTICES = MAX_VERTICES_D,
  parameter int COORD_BITS   = COORD_BITS_D,
  localparam int PB = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1,
  localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int CB = $clog2(MAX_VERTICES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vw_en,
  input  logic [PB+VB-1:0]              vw_addr,
  input  logic signed [COORD_BITS-1:0]  vw_x,
  input  logic signed [COORD_BITS-1:0]  vw_y,
  input  logic [MAX_POLYGONS-1:0][CB-1:0] size_tab,
  input  logic [MAX_POLYGONS-1:0]       hard_tab,
  input  logic                          q_valid,
  output logic                          q_pop,
  output logic                          walk_busy,
  input  logic signed [COORD_BITS-1:0]  q_x,
  input  logic signed [COORD_BITS-1:0]  q_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output out_word_t                     out_data
);

  localparam int DEPTH = MAX_POLYGONS * MAX_VERTICES;
  localparam int DB = COORD_BITS + 1;
  localparam int MB = 2 * DB;

  // vertex memory, one read port
  logic [2*COORD_BITS-1:0] mem [DEPTH];
  logic [2*COORD_BITS-1:0] rd_r;
  logic [PB+VB-1:0]        ra;

  walk_state_t st_r, st_nxt;
  logic [PB-1:0]   p_r;
  logic [CB-1:0]   i_r, n;
  logic [CB-1:0]   rdn_r;
  logic            phase_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, xi_r, yi_r, xj_r, yj_r;
  logic            inside_r, per_in_r, blk_r;
  logic [2:0]      bidx_r;
  logic signed [MB-1:0] lhs_r, rhs_r;
  logic            dypos_r, straddle_r;
  logic            last_poly, contains, ld_first;
  out_word_t       res_r;
  logic            ov_r;

  assign n = size_tab[p_r];

  always_ff @(posedge clk) begin
    if (vw_en) mem[vw_addr] <= {vw_x, vw_y};
    rd_r <= mem[ra];
  end

  // vertex i, counted from 0; wraps to vertex 0 at the end
  assign ra = {p_r, (rdn_r == n) ? VB'(0) : rdn_r[VB-1:0]};
  assign last_poly = 32'(p_r) == MAX_POLYGONS - 1;
  assign contains  = inside_r;
  assign ld_first  = (i_r == '0);

  // next state; n + 1 reads close the ring back to vertex 0
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_POLY;
      ST_POLY: begin
        if (p_r == '0 && n == '0) st_nxt = ST_OUT;
        else if (32'(n) < MIN_POLY_VERTS || (p_r != '0 && !hard_tab[p_r]))
          st_nxt = ST_NEXT;
        else st_nxt = ST_RD;
      end
      ST_RD:   st_nxt = phase_r ? ST_MUL : ST_RD;
      ST_MUL:  st_nxt = ld_first ? ST_RD : ST_CMP;
      ST_CMP:  st_nxt = (i_r == n + CB'(1)) ? ST_NEXT : ST_RD;
      ST_NEXT: begin
        if (p_r != '0 && contains && hard_tab[p_r]) st_nxt = ST_OUT;
        else if (last_poly) st_nxt = ST_OUT;
        else st_nxt = ST_POLY;
      end
      ST_OUT:  if (!ov_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    q_pop     = (st_r == ST_IDLE) && q_valid;
    walk_busy = (st_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  // datapath: rd issues the address then captures; mul forms products; cmp toggles
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        px_r <= q_x; py_r <= q_y; p_r <= '0;
        per_in_r <= 1'b1; blk_r <= 1'b0; bidx_r <= '0;
      end
      ST_POLY: begin
        i_r <= '0; rdn_r <= '0; inside_r <= 1'b0; phase_r <= 1'b0;
      end
      ST_RD: begin
        phase_r <= !phase_r;
        if (phase_r) begin
          xi_r <= rd_r[2*COORD_BITS-1:COORD_BITS];
          yi_r <= rd_r[COORD_BITS-1:0];
          xj_r <= xi_r; yj_r <= yi_r;
          rdn_r <= rdn_r + 1'b1;
        end
      end
      ST_MUL: begin
        // edge from j (previous) to i; first read only primes vertex 0
        if (!ld_first) begin
          lhs_r <= MB'((DB'(px_r) - DB'(xj_r)) * (DB'(yi_r) - DB'(yj_r)));
          rhs_r <= MB'((DB'(xi_r) - DB'(xj_r)) * (DB'(py_r) - DB'(yj_r)));
          dypos_r <= yi_r > yj_r;
          straddle_r <= (yj_r > py_r) != (yi_r > py_r);
        end
        i_r <= i_r + 1'b1;
      end
      ST_CMP: begin
        if (straddle_r && (dypos_r ? (lhs_r < rhs_r) : (rhs_r < lhs_r)))
          inside_r <= !inside_r;
      end
      ST_NEXT: begin
        if (p_r == '0) per_in_r <= inside_r;
        else if (contains && hard_tab[p_r]) begin
          blk_r <= 1'b1; bidx_r <= 3'(p_r);
        end
        if (!last_poly) p_r <= p_r + 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (st_r == ST_OUT && !ov_r) begin
      ov_r <= 1'b1;
      res_r <= '{allowed: per_in_r && !blk_r, inside_perimeter: per_in_r,
                 blocked_by_exclusion: blk_r, blocking_index: bidx_r};
    end else if (!out_stall) ov_r <= 1'b0;
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r == ST_POLY) else $error("pop outside idle");
  a_blk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.blocked_by_exclusion == (out_data.blocking_index != '0)))
    else $error("blocking index mismatch");
  a_allow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.allowed ==
      (out_data.inside_perimeter && !out_data.blocked_by_exclusion))
    else $error("allowed mismatch");
`endif

endmodule

>>> hw/rtl/geofence_point_checker.sv
// geofence_point_checker: top level joining front end and edge walker
// depends on gpc_pkg, gpc_front, gpc_back
// A query walks the edges one at a time (memory read with address then capture, multiply,
// compare) and steps through the polygons in turn, since there is one vertex read port and
// one shared multiplier pair; writes, count updates and clears wait until any queued query
// has finished.
// Queries queue two deep.
module geofence_point_checker
  import gpc_pkg::*;
#(
  parameter int MAX_POLYGONS = MAX_POLYGONS_D,
  parameter int MAX_VERTICES = MAX_VERTICES_D,
  parameter int COORD_BITS   = COORD_BITS_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int PB = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
  localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CB = $clog2(MAX_VERTICES + 1);

  logic vw_en, q_valid, q_pop, walk_busy;
  logic [PB+VB-1:0] vw_addr;
  logic signed [COORD_BITS-1:0] vw_x, vw_y, q_x, q_y;
  logic [MAX_POLYGONS-1:0][CB-1:0] size_tab;
  logic [MAX_POLYGONS-1:0] hard_tab;

  // front end
  gpc_front #(.MAX_POLYGONS(MAX_POLYGONS), .MAX_VERTICES(MAX_VERTICES),
              .COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .vw_en, .vw_addr, .vw_x, .vw_y, .size_tab, .hard_tab,
    .q_valid, .q_pop, .walk_busy, .q_x, .q_y);

  // edge walker
  gpc_back #(.MAX_POLYGONS(MAX_POLYGONS), .MAX_VERTICES(MAX_VERTICES),
             .COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst_n, .vw_en, .vw_addr, .vw_x, .vw_y, .size_tab, .hard_tab,
    .q_valid, .q_pop, .walk_busy, .q_x, .q_y, .out_valid, .out_stall, .out_data);

endmodule

>>> tb/sv/testbench.sv
// testbench: random and directed test of the geofence point checker
// depends on gpc_pkg and geofence_point_checker; holds its own polygon store and predictor
`timescale 1ns / 100ps

module testbench;
  import gpc_pkg::*;

  localparam int N_POLY  = 8;
  localparam int N_VERT  = 64;
  localparam int DRAIN   = 4 * N_POLY * N_VERT + 5 * N_POLY + 64;

  // polygon store mirror and queue of expected verdicts
  class fence_scoreboard;
    longint    vx[N_POLY*N_VERT];
    longint    vy[N_POLY*N_VERT];
    bit        written[N_POLY*N_VERT];
    int        size_tbl[N_POLY];
    bit        hard_tbl[N_POLY];
    out_word_t verdicts[$];
    int        fails;

    function new();
      foreach (vx[i]) begin
        vx[i] = 0;
        vy[i] = 0;
        written[i] = 0;
      end
      clear_all();
      fails = 0;
    endfunction

    function void clear_all();
      foreach (size_tbl[p]) begin
        size_tbl[p] = 0;
        hard_tbl[p] = 1;
      end
    endfunction

    // even-odd ray cast with exact cross products
    function bit contains(int p, longint px, longint py);
      int     n;
      int     j;
      bit     in_poly;
      longint xi, yi, xj, yj, dy, lhs, rhs;
      bit     hit;
      n = size_tbl[p];
      in_poly = 0;
      if (n < MIN_POLY_VERTS) return 0;
      j = n - 1;
      for (int i = 0; i < n; i++) begin
        xi = vx[p*N_VERT+i];
        yi = vy[p*N_VERT+i];
        xj = vx[p*N_VERT+j];
        yj = vy[p*N_VERT+j];
        if ((yi > py) != (yj > py)) begin
          dy = yj - yi;
          lhs = (px - xi) * dy;
          rhs = (xj - xi) * (py - yi);
          hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
          if (hit) in_poly = !in_poly;
        end
        j = i;
      end
      return in_poly;
    endfunction

    function void note_input(in_word_t w);
      longint    px, py;
      int        addr;
      int        cnt;
      out_word_t r;
      px = longint'($signed(w.x_coord));
      py = longint'($signed(w.y_coord));
      case (w.opcode)
        OP_WRITE_VTX: begin
          addr = int'(w.polygon_index) * N_VERT + int'(w.vertex_index);
          vx[addr] = px;
          vy[addr] = py;
          written[addr] = 1;
        end
        OP_SET_POLY: begin
          cnt = (w.vertex_count > N_VERT) ? N_VERT : int'(w.vertex_count);
          size_tbl[w.polygon_index] = cnt;
          hard_tbl[w.polygon_index] = w.hard_zone;
        end
        OP_CLEAR: clear_all();
        default: begin
          r = '0;
          r.inside_perimeter = 1;
          if (size_tbl[0] != 0) begin
            r.inside_perimeter = contains(0, px, py);
            for (int p = 1; p < N_POLY; p++) begin
              if (hard_tbl[p] && contains(p, px, py)) begin
                r.blocked_by_exclusion = 1;
                r.blocking_index = 3'(p);
                break;
              end
            end
          end
          r.allowed = r.inside_perimeter && !r.blocked_by_exclusion;
          verdicts = {verdicts, r};
        end
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        fails++;
        return;
      end
      e = verdicts.pop_front();
      if (got.allowed !== e.allowed) begin
        $display("%0t: allowed exp %0b got %0b", $time, e.allowed, got.allowed);
        fails++;
      end
      if (got.inside_perimeter !== e.inside_perimeter) begin
        $display("%0t: inside_perimeter exp %0b got %0b", $time,
                 e.inside_perimeter, got.inside_perimeter);
        fails++;
      end
      if (got.blocked_by_exclusion !== e.blocked_by_exclusion) begin
        $display("%0t: blocked_by_exclusion exp %0b got %0b", $time,
                 e.blocked_by_exclusion, got.blocked_by_exclusion);
        fails++;
      end
      if (got.blocking_index !== e.blocking_index) begin
        $display("%0t: blocking_index exp %0d got %0d", $time,
                 e.blocking_index, got.blocking_index);
        fails++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  fence_scoreboard fence_sb;
  int              in_idle_pct;
  int              out_idle_pct;
  int              words_sent;

  geofence_point_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // receiver: random stall and result check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) fence_sb.check_result(out_data);
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  // idling follows the phase of the run
  always @(posedge clk) begin
    if (words_sent < 330) begin
      in_idle_pct = 15;
      out_idle_pct = 81;
    end else if (words_sent < 660) begin
      in_idle_pct = 81;
      out_idle_pct = 15;
    end else begin
      in_idle_pct = 0;
      out_idle_pct = 0;
    end
  end

  // sender: one word, held until accepted
  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    fence_sb.note_input(w);
    words_sent++;
  endtask

  // word with random don't-care fields
  function automatic in_word_t noise_word(opcode_t op);
    in_word_t w;
    w = in_word_t'(67'({$urandom, $urandom, $urandom}));
    w.opcode = op;
    return w;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  task automatic write_vertex(int p, int v, longint x, longint y);
    in_word_t w;
    w = noise_word(OP_WRITE_VTX);
    w.polygon_index = 3'(p);
    w.vertex_index = 6'(v);
    w.x_coord = clamp24(x);
    w.y_coord = clamp24(y);
    send_word(w);
  endtask

  // count is cut back where it would reach unwritten vertices
  task automatic set_polygon(int p, int cnt, bit hard);
    in_word_t w;
    int       eff;
    int       lead;
    eff = (cnt > N_VERT) ? N_VERT : cnt;
    lead = 0;
    while (lead < N_VERT && fence_sb.written[p*N_VERT+lead]) lead++;
    if (eff >= MIN_POLY_VERTS && lead < eff) cnt = (lead >= MIN_POLY_VERTS) ? lead
                                                  : $urandom_range(0, 2);
    w = noise_word(OP_SET_POLY);
    w.polygon_index = 3'(p);
    w.vertex_count = 7'(cnt);
    w.hard_zone = hard;
    send_word(w);
  endtask

  task automatic query_point(longint x, longint y);
    in_word_t w;
    w = noise_word(OP_QUERY);
    w.x_coord = clamp24(x);
    w.y_coord = clamp24(y);
    send_word(w);
  endtask

  task automatic clear_all();
    send_word(noise_word(OP_CLEAR));
  endtask

  function automatic longint spread(longint r);
    return longint'($urandom_range(0, 2 * r)) - r;
  endfunction

  // random episode: build a polygon, then query around it
  task automatic polygon_episode();
    int     p;
    int     n;
    int     cnt;
    longint cx, cy, r;
    if ($urandom_range(0, 5) == 0) clear_all();
    p = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 7);
    n = ($urandom_range(0, 19) == 0) ? N_VERT : $urandom_range(3, 8);
    if ($urandom_range(0, 7) == 0) begin
      cx = 0;
      cy = 0;
      r = 8388608;
    end else begin
      cx = spread(4194304);
      cy = spread(4194304);
      r = $urandom_range(1, 1 << $urandom_range(1, 21));
    end
    for (int v = 0; v < n; v++) write_vertex(p, v, cx + spread(r), cy + spread(r));
    if (n == N_VERT) cnt = $urandom_range(N_VERT, 127);
    else cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : n;
    set_polygon(p, cnt, $urandom_range(0, 1));
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 5) == 0) begin
        query_point(fence_sb.vx[p*N_VERT], fence_sb.vy[p*N_VERT]);
      end else if ($urandom_range(0, 7) == 0) begin
        query_point(spread(8388608), spread(8388608));
      end else begin
        query_point(cx + spread(2 * r), cy + spread(2 * r));
      end
    end
  endtask

  initial begin
    #(20.0 * 20000000);
    $display("** geofence_point_checker: FAILED **");
    $finish;
  end

  initial begin
    fence_sb = new();
    words_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty perimeter, extreme triangle, hard and soft exclusion
    query_point(-8388608, 8388607);
    write_vertex(0, 0, -8388608, -8388608);
    write_vertex(0, 1, 8388607, -8388608);
    write_vertex(0, 2, 0, 8388607);
    set_polygon(0, 3, 1'b0);
    query_point(0, 0);
    query_point(8388607, 8388607);
    query_point(-8388608, -8388608);
    write_vertex(1, 0, -100, -100);
    write_vertex(1, 1, 100, -100);
    write_vertex(1, 2, 0, 100);
    write_vertex(7, 63, 8388607, 8388607);
    set_polygon(1, 3, 1'b1);
    query_point(0, 0);
    query_point(8388607, 0);
    set_polygon(1, 3, 1'b0);
    query_point(0, 0);
    set_polygon(0, 2, 1'b1);
    query_point(0, 0);
    clear_all();
    query_point(0, 0);

    while (words_sent < 1000) polygon_episode();
    in_valid <= 1'b0;

    // drain the expected verdicts, then watch for strays
    while (fence_sb.verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fence_sb.fails == 0 && fence_sb.verdicts.size() == 0) begin
      $display("** geofence_point_checker: PASSED **");
    end else begin
      $display("** geofence_point_checker: FAILED **");
    end
    $finish;
  end

endmodule
